// ===== design/bst_pkg.sv =====
`timescale 1ns / 1ps

package bst_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned LINE_W    = 32;
  localparam int unsigned MASK_W    = 10;
  localparam int unsigned TDATA_W   = 48;
  localparam int unsigned TUSER_W   = 2;
  localparam int unsigned MAX_RES   = 3;
  localparam int unsigned OUT_DEPTH = 4;

  localparam logic [MASK_W-1:0] MASK_RESET = 10'd63;
  localparam logic [LINE_W-1:0] LINE_RESET = 32'd1;
  localparam logic [LINE_W-1:0] LINE_MAX   = '1;

  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_PIPE   = 8'h7C;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_BANG   = 8'h21;
  localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_VT     = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF     = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_ESC_AT_END  = 2'd1,
    ERR_QUOTE_EOL   = 2'd2,
    ERR_QUOTE_SPACE = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_WORD     = 3'd1,
    MODE_QUOTE    = 3'd2,
    MODE_QESC     = 3'd3,
    MODE_COMMENT  = 3'd4,
    MODE_SKIPLINE = 3'd5
  } mode_e;

  typedef enum logic {
    REG_SPECIAL_MASK = 1'b0,
    REG_START_LINE   = 1'b1
  } reg_e;

  typedef struct packed {
    kind_e              kind;
    logic [CHAR_W-1:0]  ch;
    logic               quoted;
    err_e               err;
    logic [LINE_W-1:0]  line;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [1:0]          n;
    res_t [MAX_RES-1:0]  r;
  } push_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic is_special(input logic [CHAR_W-1:0] c,
                                      input logic [MASK_W-1:0] mask);
    logic hit;
    hit = 1'b0;
    case (c)
      CH_LPAREN: hit = mask[0];
      CH_RPAREN: hit = mask[1];
      CH_LBRACE: hit = mask[2];
      CH_RBRACE: hit = mask[3];
      CH_COLON:  hit = mask[4];
      CH_COMMA:  hit = mask[5];
      CH_NL:     hit = mask[6];
      CH_PIPE:   hit = mask[7];
      CH_PLUS:   hit = mask[8];
      CH_BANG:   hit = mask[9];
      default:   hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ===== design/bst_lexer.sv =====
`timescale 1ns / 1ps

module bst_lexer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [bst_pkg::CHAR_W-1:0] in_char_i,
  input  logic                  in_flush_i,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [bst_pkg::LINE_W-1:0] cfg_wdata_i,
  input  logic                  space_ok_i,
  output bst_pkg::push_t        push_o
);
  import bst_pkg::*;

  logic              valid_q;
  logic [CHAR_W-1:0] char_q;
  logic              flush_q;
  logic              adv;

  mode_e             mode_q, mode_d;
  logic              open_q, open_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic [MASK_W-1:0] mask_q;

  logic              c_space, c_special, c_nl;
  logic [LINE_W-1:0] bumped, idle_line;
  logic              run_idle, end_first;
  logic [1:0]        b0, b1, n;
  res_t [MAX_RES-1:0] r;

  function automatic res_t mk(input kind_e k, input logic [CHAR_W-1:0] ch,
                              input logic q, input err_e e,
                              input logic [LINE_W-1:0] ln);
    res_t x;
    x.kind   = k;
    x.ch     = ch;
    x.quoted = q;
    x.err    = e;
    x.line   = ln;
    x.last   = 1'b0;
    return x;
  endfunction

  assign adv        = valid_q && space_ok_i;
  assign in_ready_o = !valid_q || adv;

  // input request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q  <= in_char_i;
      flush_q <= in_flush_i;
    end
  end

  assign c_space   = is_space(char_q);
  assign c_special = is_special(char_q, mask_q);
  assign c_nl      = (char_q == CH_NL);
  assign bumped    = (line_q == LINE_MAX) ? line_q : line_q + LINE_W'(1);
  assign idle_line = c_nl ? bumped : line_q;

  always_comb begin
    mode_d    = mode_q;
    open_d    = open_q;
    line_d    = line_q;
    n         = 2'd0;
    run_idle  = 1'b0;
    end_first = 1'b0;
    for (int i = 0; i < MAX_RES; i++) begin
      r[i] = mk(KIND_CHAR, '0, 1'b0, ERR_NONE, line_q);
    end

    if (flush_q) begin
      case (mode_q)
        MODE_WORD: begin
          r[0] = mk(KIND_END, '0, 1'b0, ERR_NONE, line_q);
          n    = 2'd1;
        end
        MODE_QUOTE: begin
          if (open_q) begin
            r[0] = mk(KIND_END, '0, 1'b1, ERR_NONE, line_q);
            n    = 2'd1;
          end
        end
        MODE_QESC: begin
          r[0] = mk(KIND_ERROR, '0, 1'b1, ERR_ESC_AT_END, line_q);
          n    = 2'd1;
        end
        MODE_SKIPLINE: line_d = bumped;
        default: ;
      endcase
      mode_d = MODE_IDLE;
      open_d = 1'b0;
    end else begin
      case (mode_q)
        MODE_WORD: begin
          if (c_space || c_special) begin
            r[0]      = mk(KIND_END, '0, 1'b0, ERR_NONE, line_q);
            n         = 2'd1;
            end_first = 1'b1;
            run_idle  = 1'b1;
          end else begin
            r[0] = mk(KIND_CHAR, char_q, 1'b0, ERR_NONE, line_q);
            n    = 2'd1;
          end
        end
        MODE_QUOTE: begin
          if (char_q == CH_BSLASH) begin
            mode_d = MODE_QESC;
          end else if (char_q == CH_DQUOTE) begin
            if (open_q) begin
              r[0] = mk(KIND_END, '0, 1'b1, ERR_NONE, line_q);
              n    = 2'd1;
            end
            mode_d = MODE_IDLE;
            open_d = 1'b0;
          end else if (c_nl) begin
            r[0]   = mk(KIND_ERROR, '0, 1'b1, ERR_QUOTE_EOL, line_q);
            n      = 2'd1;
            mode_d = MODE_IDLE;
            open_d = 1'b0;
          end else if (!open_q && c_space) begin
            r[0]   = mk(KIND_ERROR, '0, 1'b1, ERR_QUOTE_SPACE, line_q);
            n      = 2'd1;
            mode_d = MODE_IDLE;
            open_d = 1'b0;
          end else begin
            r[0]   = mk(KIND_CHAR, char_q, 1'b1, ERR_NONE, line_q);
            n      = 2'd1;
            open_d = 1'b1;
          end
        end
        MODE_QESC: begin
          r[0]   = mk(KIND_CHAR, char_q, 1'b1, ERR_NONE, line_q);
          n      = 2'd1;
          open_d = 1'b1;
          mode_d = MODE_QUOTE;
        end
        MODE_COMMENT: begin
          if (c_nl) begin
            run_idle = 1'b1;
          end
        end
        MODE_SKIPLINE: begin
          if (c_nl) begin
            line_d = bumped;
            mode_d = MODE_IDLE;
          end
        end
        default: run_idle = 1'b1;
      endcase
    end

    // between-tokens handling, after any end of token from a word
    b0 = {1'b0, end_first};
    b1 = b0 + 2'd1;
    if (run_idle) begin
      mode_d = MODE_IDLE;
      open_d = 1'b0;
      if (c_nl) begin
        line_d = bumped;
      end
      if (c_special) begin
        r[b0] = mk(KIND_CHAR, char_q, 1'b0, ERR_NONE, idle_line);
        r[b1] = mk(KIND_END, '0, 1'b0, ERR_NONE, idle_line);
        n     = n + 2'd2;
      end else if (char_q == CH_DQUOTE) begin
        mode_d = MODE_QUOTE;
      end else if (c_space) begin
        mode_d = MODE_IDLE;
      end else if (char_q == CH_HASH) begin
        mode_d = MODE_COMMENT;
      end else if (char_q == CH_BSLASH) begin
        mode_d = MODE_SKIPLINE;
      end else begin
        r[b0]  = mk(KIND_CHAR, char_q, 1'b0, ERR_NONE, idle_line);
        n      = n + 2'd1;
        open_d = 1'b1;
        mode_d = MODE_WORD;
      end
    end

    case (n)
      2'd1:    r[0].last = 1'b1;
      2'd2:    r[1].last = 1'b1;
      2'd3:    r[2].last = 1'b1;
      default: ;
    endcase

    push_o.r = r;
    push_o.n = adv ? n : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      open_q <= 1'b0;
      line_q <= LINE_RESET;
      mask_q <= MASK_RESET;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_SPECIAL_MASK: mask_q <= cfg_wdata_i[MASK_W-1:0];
        REG_START_LINE:   line_q <= cfg_wdata_i;
        default: ;
      endcase
    end else if (adv) begin
      mode_q <= mode_d;
      open_q <= open_d;
      line_q <= line_d;
    end
  end

  a_flush_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && flush_q && !cfg_we_i) |=> (mode_q == MODE_IDLE && !open_q))
    else $error("tokenizer not idle after end of input");

  a_line_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> (line_q >= $past(line_q)))
    else $error("line count went backward");

endmodule

// ===== design/bst_out_fifo.sv =====
`timescale 1ns / 1ps

module bst_out_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bst_pkg::push_t push_i,
  output logic           space_ok_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bst_pkg::res_t  out_res_o
);
  import bst_pkg::*;

  localparam int unsigned DEPTH = OUT_DEPTH;
  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  res_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] count_q;
  logic          pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_res_o   = mem_q[rd_q];
  assign space_ok_o  = (count_q <= CW'(DEPTH - MAX_RES));

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push_i.n) begin
        mem_q[wr_q + PW'(i)] <= push_i.r[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + PW'(push_i.n);
      rd_q    <= rd_q + PW'(pop);
      count_q <= count_q + CW'(push_i.n) - CW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != 2'd0) |-> (count_q <= CW'(DEPTH - MAX_RES)))
    else $error("results pushed without room");

endmodule

// ===== design/build_script_tokenizer.sv =====
`timescale 1ns / 1ps

// Build-script tokenizer. One character request per clock is accepted on the
// s_axis side (tlast marks end of input and closes any open token); each
// request yields zero to three results on m_axis: token characters, end of
// token marks and syntax errors, each tagged with the line count. A request
// is held in the input register, where the lexer logic runs, and its results
// enter a four-entry result queue that drains one result per cycle, so
// sustained input is one character per clock whenever the consumer keeps up
// with the result count. The input stalls while fewer than three queue slots
// are free. Configuration writes must go in only while the block is idle
// (not enforced here); writing start_line also reloads the line counter.
module build_script_tokenizer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] char_code
  input  logic                        s_axis_tlast,  // flush
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [7:0] token_char, [8] quoted, [10:9] error_code, [42:11] line
  output logic [bst_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [bst_pkg::TUSER_W-1:0] m_axis_tuser,  // [1:0] result_kind
  output logic                        m_axis_tlast,  // last
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [bst_pkg::LINE_W-1:0]  cfg_wdata_i
);
  import bst_pkg::*;

  push_t push;
  logic  space_ok;
  res_t  head;

  bst_lexer u_lexer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_char_i  (s_axis_tdata),
    .in_flush_i (s_axis_tlast),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .space_ok_i (space_ok),
    .push_o     (push)
  );

  bst_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .space_ok_o (space_ok),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_res_o  (head)
  );

  assign m_axis_tdata = {5'd0, head.line, head.err, head.quoted, head.ch};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import bst_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic                clk = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]  m_axis_tdata;
  logic [TUSER_W-1:0]  m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_we_i = 1'b0;
  reg_e                cfg_idx_i = REG_SPECIAL_MASK;
  logic [LINE_W-1:0]   cfg_wdata_i = '0;

  build_script_tokenizer dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #4 clk = ~clk;

  // directed script; typed rows carry the result count and the kind/error of the final result
  typedef struct packed {
    logic [7:0] ch;
    logic       fl;
    logic       typed;
    logic [1:0] n;
    kind_e      kind;
    err_e       err;
  } row_t;

  row_t script_rows [29] = '{
    '{CH_LPAREN, 1'b0, 1'b1, 2'd2, KIND_END,   ERR_NONE},
    '{8'h00,     1'b0, 1'b0, 2'd0, KIND_CHAR,  ERR_NONE},
    '{8'hFF,     1'b0, 1'b0, 2'd0, KIND_CHAR,  ERR_NONE},
    '{CH_SPACE,  1'b0, 1'b1, 2'd1, KIND_END,   ERR_NONE},
    '{8'h62,     1'b0, 1'b0, 2'd0, KIND_CHAR,  ERR_NONE},
    '{CH_RPAREN, 1'b0, 1'b1, 2'd3, KIND_END,   ERR_NONE},
    '{CH_DQUOTE, 1'b0, 1'b1, 2'd0, KIND_CHAR,  ERR_NONE},
    '{CH_SPACE,  1'b0, 1'b1, 2'd1, KIND_ERROR, ERR_QUOTE_SPACE},
    '{CH_DQUOTE, 1'b0, 1'b0, 2'd0, KIND_CHAR,  ERR_NONE},
    '{8'h78,     1'b0, 1'b0, 2'd0, KIND_CHAR,  ERR_NONE},
    '{CH_BSLASH, 1'b0, 1'b0, 2'd0, KIND_CHAR,  ERR_NONE},
    '{CH_DQUOTE, 1'b0, 1'b0, 2'd0, KIND_CHAR,  ERR_NONE},
    '{CH_DQUOTE, 1'b0, 1'b1, 2'd1, KIND_END,   ERR_NONE},
    '{CH_DQUOTE, 1'b0, 1'b0, 2'd0, KIND_CHAR,  ERR_NONE},
    '{CH_DQUOTE, 1'b0, 1'b1, 2'd0, KIND_CHAR,  ERR_NONE},
    '{CH_DQUOTE, 1'b0, 1'b0, 2'd0, KIND_CHAR,  ERR_NONE},
    '{CH_NL,     1'b0, 1'b1, 2'd1, KIND_ERROR, ERR_QUOTE_EOL},
    '{CH_HASH,   1'b0, 1'b0, 2'd0, KIND_CHAR,  ERR_NONE},
    '{8'h7A,     1'b0, 1'b1, 2'd0, KIND_CHAR,  ERR_NONE},
    '{CH_NL,     1'b0, 1'b0, 2'd0, KIND_CHAR,  ERR_NONE},
    '{CH_BSLASH, 1'b0, 1'b0, 2'd0, KIND_CHAR,  ERR_NONE},
    '{8'h71,     1'b0, 1'b0, 2'd0, KIND_CHAR,  ERR_NONE},
    '{8'h00,     1'b1, 1'b1, 2'd0, KIND_CHAR,  ERR_NONE},
    '{CH_DQUOTE, 1'b0, 1'b0, 2'd0, KIND_CHAR,  ERR_NONE},
    '{8'h61,     1'b0, 1'b0, 2'd0, KIND_CHAR,  ERR_NONE},
    '{CH_BSLASH, 1'b0, 1'b0, 2'd0, KIND_CHAR,  ERR_NONE},
    '{8'hFF,     1'b1, 1'b1, 2'd1, KIND_ERROR, ERR_ESC_AT_END},
    '{8'hFF,     1'b0, 1'b0, 2'd0, KIND_CHAR,  ERR_NONE},
    '{8'h00,     1'b1, 1'b1, 2'd1, KIND_END,   ERR_NONE}
  };

  logic [7:0] punct [10] = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_COLON,
                             CH_COMMA, CH_NL, CH_PIPE, CH_PLUS, CH_BANG};
  logic [7:0] blanks [6] = '{CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR};

  // tag travelling with each request for the typed rows
  logic       tag_typed = 1'b0;
  logic [1:0] tag_n = '0;
  kind_e      tag_kind = KIND_CHAR;
  err_e       tag_err = ERR_NONE;

  // lexer state mirror
  mode_e             lx_mode = MODE_IDLE;
  logic              lx_open = 1'b0;
  logic [LINE_W-1:0] lx_line = LINE_RESET;
  logic [MASK_W-1:0] lx_mask = MASK_RESET;

  res_t step_buf [$];
  res_t token_q [$];

  int faults = 0;
  int chars_sent = 0;
  int results_seen = 0;
  int stall_cycles = 0;
  int burst_left = 0;
  bit hold_ask = 1'b0;
  bit hold_done = 1'b0;

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  function automatic bit punct_on(input logic [7:0] c, input logic [MASK_W-1:0] m);
    for (int i = 0; i < 10; i++)
      if (c == punct[i]) return m[i];
    return 1'b0;
  endfunction

  task automatic add_res(input kind_e k, input logic [7:0] c, input logic q, input err_e e);
    res_t r;
    r.kind = k;
    r.ch = c;
    r.quoted = q;
    r.err = e;
    r.line = lx_line;
    r.last = 1'b0;
    step_buf.push_back(r);
  endtask

  task automatic bump_line();
    if (lx_line != LINE_MAX) lx_line = lx_line + 1;
  endtask

  task automatic raise_error(input err_e e);
    add_res(KIND_ERROR, 8'h00, 1'b1, e);
    lx_mode = MODE_IDLE;
    lx_open = 1'b0;
  endtask

  task automatic start_fresh(input logic [7:0] c);
    lx_mode = MODE_IDLE;
    lx_open = 1'b0;
    if (c == CH_NL) bump_line();
    if (punct_on(c, lx_mask)) begin
      add_res(KIND_CHAR, c, 1'b0, ERR_NONE);
      add_res(KIND_END, 8'h00, 1'b0, ERR_NONE);
    end else if (c == CH_DQUOTE) begin
      lx_mode = MODE_QUOTE;
    end else if (is_blank(c)) begin
    end else if (c == CH_HASH) begin
      lx_mode = MODE_COMMENT;
    end else if (c == CH_BSLASH) begin
      lx_mode = MODE_SKIPLINE;
    end else begin
      add_res(KIND_CHAR, c, 1'b0, ERR_NONE);
      lx_open = 1'b1;
      lx_mode = MODE_WORD;
    end
  endtask

  task automatic lex_char(input logic [7:0] c, input logic fl);
    step_buf.delete();
    if (fl) begin
      case (lx_mode)
        MODE_WORD:     add_res(KIND_END, 8'h00, 1'b0, ERR_NONE);
        MODE_QUOTE:    if (lx_open) add_res(KIND_END, 8'h00, 1'b1, ERR_NONE);
        MODE_QESC:     add_res(KIND_ERROR, 8'h00, 1'b1, ERR_ESC_AT_END);
        MODE_SKIPLINE: bump_line();
        default: ;
      endcase
      lx_mode = MODE_IDLE;
      lx_open = 1'b0;
    end else begin
      case (lx_mode)
        MODE_WORD: begin
          if (is_blank(c) || punct_on(c, lx_mask)) begin
            add_res(KIND_END, 8'h00, 1'b0, ERR_NONE);
            start_fresh(c);
          end else begin
            add_res(KIND_CHAR, c, 1'b0, ERR_NONE);
          end
        end
        MODE_QUOTE: begin
          if (c == CH_BSLASH) begin
            lx_mode = MODE_QESC;
          end else if (c == CH_DQUOTE) begin
            if (lx_open) add_res(KIND_END, 8'h00, 1'b1, ERR_NONE);
            lx_mode = MODE_IDLE;
            lx_open = 1'b0;
          end else if (c == CH_NL) begin
            raise_error(ERR_QUOTE_EOL);
          end else if (!lx_open && is_blank(c)) begin
            raise_error(ERR_QUOTE_SPACE);
          end else begin
            add_res(KIND_CHAR, c, 1'b1, ERR_NONE);
            lx_open = 1'b1;
          end
        end
        MODE_QESC: begin
          add_res(KIND_CHAR, c, 1'b1, ERR_NONE);
          lx_open = 1'b1;
          lx_mode = MODE_QUOTE;
        end
        MODE_COMMENT: if (c == CH_NL) start_fresh(c);
        MODE_SKIPLINE: begin
          if (c == CH_NL) begin
            bump_line();
            lx_mode = MODE_IDLE;
          end
        end
        default: start_fresh(c);
      endcase
    end
    if (step_buf.size() > 0) step_buf[step_buf.size()-1].last = 1'b1;
    foreach (step_buf[i]) token_q.push_back(step_buf[i]);
  endtask

  always @(posedge clk) begin : monitor
    res_t want;
    int n;
    bit moved;
    kind_e got_kind;
    err_e got_err;
    moved = 1'b0;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_SPECIAL_MASK) begin
          lx_mask = cfg_wdata_i[MASK_W-1:0];
        end else begin
          lx_line = cfg_wdata_i;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        lex_char(s_axis_tdata, s_axis_tlast);
        n = step_buf.size();
        got_kind = KIND_CHAR;
        got_err = ERR_NONE;
        if (n > 0) begin
          got_kind = step_buf[n-1].kind;
          got_err = step_buf[n-1].err;
        end
        if (tag_typed && (n != tag_n || (n > 0 &&
            (got_kind != tag_kind || got_err != tag_err)))) begin
          $display("%0t: script row %h/%0b: expected %0d results ending kind %0d err %0d",
                   $time, s_axis_tdata, s_axis_tlast, tag_n, tag_kind, tag_err);
          $display("%0t:           got %0d results ending kind %0d err %0d",
                   $time, n, got_kind, got_err);
          faults++;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        results_seen++;
        if (token_q.size() == 0) begin
          $display("%0t: unexpected result, got kind %0d data %h last %0b",
                   $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
          faults++;
        end else begin
          want = token_q.pop_front();
          if (m_axis_tuser !== want.kind || m_axis_tdata[7:0] !== want.ch ||
              m_axis_tdata[8] !== want.quoted || m_axis_tdata[10:9] !== want.err ||
              m_axis_tdata[42:11] !== want.line || m_axis_tdata[47:43] !== '0 ||
              m_axis_tlast !== want.last) begin
            $display("%0t: mismatch, expected kind %0d char %h q %0b err %0d line %0d last %0b",
                     $time, want.kind, want.ch, want.quoted, want.err, want.line, want.last);
            $display("%0t:           got kind %0d char %h q %0b err %0d line %0d last %0b pad %h",
                     $time, m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[8],
                     m_axis_tdata[10:9], m_axis_tdata[42:11], m_axis_tlast,
                     m_axis_tdata[47:43]);
            faults++;
          end
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("build_script_tokenizer test failed");
    $finish;
  end

  // result side: always-ready runs, random stalls, short blocks, one long hold-off
  initial begin : drain_side
    int style;
    int span;
    forever begin
      style = $urandom_range(0, 9);
      span = $urandom_range(4, 40);
      if (style >= 8) span = $urandom_range(1, 8);
      if (hold_ask && !hold_done) begin
        hold_done = 1'b1;
        style = 10;
        span = 90;
      end
      repeat (span) begin
        if (style < 4) m_axis_tready <= 1'b1;
        else if (style < 8) m_axis_tready <= ($urandom_range(0, 2) != 0);
        else m_axis_tready <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic send_req(input logic [7:0] c, input logic fl, input logic tp,
                          input logic [1:0] n, input kind_e k, input err_e e);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tlast <= fl;
    tag_typed <= tp;
    tag_n <= n;
    tag_kind <= k;
    tag_err <= e;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic put(input logic [7:0] c, input logic fl = 1'b0);
    send_req(c, fl, 1'b0, 2'd0, KIND_CHAR, ERR_NONE);
  endtask

  function automatic logic [7:0] word_byte();
    case ($urandom_range(0, 9))
      0: return 8'h80 + 8'($urandom_range(0, 127));
      1: return 8'h30 + 8'($urandom_range(0, 9));
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (token_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_e idx, input logic [LINE_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk);
    cfg_we_i <= 1'b0;
    @(posedge clk);
  endtask

  task automatic put_fragment();
    int pick;
    int k;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      repeat ($urandom_range(1, 6)) put(word_byte());
    end else if (pick < 45) begin
      repeat ($urandom_range(1, 3)) put(blanks[$urandom_range(0, 5)]);
    end else if (pick < 58) begin
      put(punct[$urandom_range(0, 9)]);
    end else if (pick < 72) begin
      put(CH_DQUOTE);
      k = $urandom_range(0, 5);
      for (int j = 0; j < k; j++) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            put(CH_BSLASH);
            put(8'($urandom_range(0, 255)));
          end
          2: put((j > 0) ? CH_SPACE : word_byte());
          default: put(word_byte());
        endcase
      end
      if ($urandom_range(0, 9) == 0) put(8'($urandom_range(0, 255)), 1'b1);
      else put(CH_DQUOTE);
    end else if (pick < 78) begin
      put(CH_NL);
    end else if (pick < 83) begin
      put(CH_HASH);
      repeat ($urandom_range(0, 5)) put(8'($urandom_range(0, 255)));
      put(CH_NL);
    end else if (pick < 87) begin
      put(CH_BSLASH);
      repeat ($urandom_range(0, 4)) put(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0) put(CH_NL);
      else put(8'($urandom_range(0, 255)), 1'b1);
    end else if (pick < 91) begin
      put(CH_DQUOTE);
      if ($urandom_range(0, 1) == 0) put(word_byte());
      case ($urandom_range(0, 2))
        0: put(blanks[$urandom_range(0, 5)]);
        1: put(CH_NL);
        default: begin
          put(CH_BSLASH);
          put(8'($urandom_range(0, 255)), 1'b1);
        end
      endcase
    end else if (pick < 95) begin
      put(8'($urandom_range(0, 255)), 1'b1);
    end else begin
      put(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(input logic [MASK_W-1:0] m, input logic [LINE_W-1:0] ln,
                           input int count, input bit long_hold);
    int start;
    wait_idle();
    write_reg(REG_SPECIAL_MASK, LINE_W'(m));
    write_reg(REG_START_LINE, ln);
    start = chars_sent;
    while (chars_sent - start < count) begin
      if (long_hold && chars_sent - start >= 10) hold_ask = 1'b1;
      put_fragment();
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    foreach (script_rows[i])
      send_req(script_rows[i].ch, script_rows[i].fl, script_rows[i].typed,
               script_rows[i].n, script_rows[i].kind, script_rows[i].err);

    run_phase(10'h3FF, 32'd0, 82, 1'b1);
    run_phase(10'h000, 32'hFFFF_FFFD, 82, 1'b0);
    run_phase(MASK_W'($urandom_range(0, 1023)), $urandom, 82, 1'b0);
    run_phase(MASK_RESET, LINE_RESET, 82, 1'b0);

    wait_idle();
    $display("%0d characters sent, %0d results checked", chars_sent, results_seen);
    $display("covered reset, full and empty masks, line counter saturation and random setup");
    if (faults == 0) begin
      $display("build_script_tokenizer test passed");
    end else begin
      $display("build_script_tokenizer test failed");
    end
    $finish;
  end

endmodule
